// ===== hw/rtl/xml_utf8_char_reader_macros.svh =====
// Assertion macros shared by the XML UTF-8 character reader RTL.
// Uses clk and rst_n of the including module; empty under synthesis.
`ifndef XML_UTF8_CHAR_READER_MACROS_SVH
`define XML_UTF8_CHAR_READER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define XUCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define XUCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define XUCR_ASSERT_IMPL(lbl, ante, cons, msg)
`define XUCR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/xucr_pkg.sv =====
// Package of the XML UTF-8 character reader: types, constants, XML Char check.
// No dependencies; used by every module of the block.
package xucr_pkg;

  // Width of the internal line and column counters (saturating).
  localparam int POS_BITS   = 32;
  localparam int FIELD_W    = 32;
  localparam int CP_W       = 21;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  // Result queue; depth must be a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END      = 2'd1,
    KIND_BAD_UTF8 = 2'd2,
    KIND_NOT_CHAR = 2'd3
  } kind_t;

  // Byte constants
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_ASCII_END = 8'h80;
  localparam logic [7:0] CONT_LO      = 8'h80;
  localparam logic [7:0] CONT_HI      = 8'hBF;
  localparam logic [7:0] LEAD2_LO     = 8'hC2;
  localparam logic [7:0] LEAD2_HI     = 8'hDF;
  localparam logic [7:0] LEAD3_LO     = 8'hE0;
  localparam logic [7:0] LEAD3_SURR   = 8'hED;
  localparam logic [7:0] LEAD3_HI     = 8'hEF;
  localparam logic [7:0] LEAD4_LO     = 8'hF0;
  localparam logic [7:0] LEAD4_HI     = 8'hF4;
  localparam logic [7:0] E0_LO        = 8'hA0;
  localparam logic [7:0] ED_HI        = 8'h9F;
  localparam logic [7:0] F0_LO        = 8'h90;
  localparam logic [7:0] F4_HI        = 8'h8F;

  // Code point constants
  localparam logic [CP_W-1:0] CP_TAB       = 21'h00009;
  localparam logic [CP_W-1:0] CP_LF        = 21'h0000A;
  localparam logic [CP_W-1:0] CP_CR        = 21'h0000D;
  localparam logic [CP_W-1:0] CP_SPACE     = 21'h00020;
  localparam logic [CP_W-1:0] CP_BMP_LO_HI = 21'h0D7FF;
  localparam logic [CP_W-1:0] CP_BMP_HI_LO = 21'h0E000;
  localparam logic [CP_W-1:0] CP_BMP_HI_HI = 21'h0FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_LO   = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

  typedef struct packed {
    kind_t                kind;
    logic [CP_W-1:0]      cp;
    logic [FIELD_W-1:0]   line;
    logic [FIELD_W-1:0]   col;
    logic                 fin;
  } res_t;

  // Up to two results pushed per accepted byte, packed from slot0.
  typedef struct packed {
    logic [1:0] n;
    res_t       slot0;
    res_t       slot1;
  } push_t;

  function automatic logic is_xml_char(input logic [CP_W-1:0] cp);
    return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
           (cp >= CP_SPACE && cp <= CP_BMP_LO_HI) ||
           (cp >= CP_BMP_HI_LO && cp <= CP_BMP_HI_HI) ||
           (cp >= CP_SUPP_LO && cp <= CP_MAX);
  endfunction

endpackage

// ===== hw/rtl/xml_utf8_char_reader.sv =====
// Top level of the XML UTF-8 character reader: byte in, characters out.
// Results enter the result queue as their byte is accepted; out_* shows the queue head.
// Throughput: one byte per cycle while in_stall is low; the last byte of an entity,
// when it also gives a character or error, yields two results for the queue to drain.
// The four-entry result queue sets the rate: in_stall rises when it holds over two.
// Reset: synchronous, active-low rst_n clears decoder, positions and the queue.
module xml_utf8_char_reader (
  input  logic        clk,
  input  logic        rst_n,
  // byte request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  // result request channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [20:0] out_code_point,
  output logic [31:0] out_line_number,
  output logic [31:0] out_column_number,
  output logic        out_final_of_run
);
  import xucr_pkg::*;

  logic  acc;
  push_t push;
  res_t  head;
  logic  no_room;

  // Accept a byte whenever the queue can take both results it may cause.
  assign in_stall = no_room;
  assign acc      = in_valid && !no_room;

  // Decode the byte and update state in the same cycle; results go to the queue.
  xucr_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .byte_value (in_byte_value),
    .last_byte  (in_last_byte),
    .push       (push)
  );

  // Buffer results so input keeps flowing while the consumer stalls.
  xucr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .no_room   (no_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Drive the result fields straight from the queue head.
  assign out_kind          = head.kind;
  assign out_code_point    = head.cp;
  assign out_line_number   = head.line;
  assign out_column_number = head.col;
  assign out_final_of_run  = head.fin;

endmodule

// ===== hw/rtl/xucr_decode.sv =====
// UTF-8 decoder state, XML Char check, line-end handling and positions.
// Depends on xucr_pkg; produces up to two results per accepted byte.
`include "xml_utf8_char_reader_macros.svh"

module xucr_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [7:0]     byte_value,
  input  logic           last_byte,
  output xucr_pkg::push_t push
);
  import xucr_pkg::*;

  logic [CP_W-1:0]     part_r, part_nxt;
  logic [1:0]          need_r, need_nxt;
  logic [7:0]          lo_r, lo_nxt;
  logic [7:0]          hi_r, hi_nxt;
  logic                cr_r, cr_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt;
  logic [POS_BITS-1:0] col_r, col_nxt;
  logic                err_seen_r, err_seen_nxt;

  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] acc_cp;
  logic            complete;
  logic            err_vld;
  kind_t           err_kind;
  logic            r0_vld;
  res_t            r0;
  res_t            r_end;

  always_comb begin
    part_nxt     = part_r;
    need_nxt     = need_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    cr_nxt       = cr_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    err_seen_nxt = err_seen_r;
    cp           = '0;
    acc_cp       = {part_r[CP_W-7:0], byte_value[5:0]};
    complete     = 1'b0;
    err_vld      = 1'b0;
    err_kind     = KIND_BAD_UTF8;
    r0_vld       = 1'b0;
    r0           = '0;
    r_end        = '0;

    if (!err_seen_r) begin
      cr_nxt = 1'b0;
      if (need_r == 2'd0) begin
        if (byte_value < BYTE_ASCII_END) begin
          // drop the LF of a CR-LF pair
          if (!(cr_r && byte_value == BYTE_LF)) begin
            cp       = CP_W'(byte_value);
            complete = 1'b1;
          end
        end else if (byte_value >= LEAD2_LO && byte_value <= LEAD2_HI) begin
          need_nxt = 2'd1;
          part_nxt = CP_W'(byte_value[4:0]);
        end else if (byte_value >= LEAD3_LO && byte_value <= LEAD3_HI) begin
          if (byte_value == LEAD3_LO) lo_nxt = E0_LO;
          if (byte_value == LEAD3_SURR) hi_nxt = ED_HI;
          need_nxt = 2'd2;
          part_nxt = CP_W'(byte_value[3:0]);
        end else if (byte_value >= LEAD4_LO && byte_value <= LEAD4_HI) begin
          if (byte_value == LEAD4_LO) lo_nxt = F0_LO;
          if (byte_value == LEAD4_HI) hi_nxt = F4_HI;
          need_nxt = 2'd3;
          part_nxt = CP_W'(byte_value[2:0]);
        end else begin
          err_vld = 1'b1;
        end
      end else if (byte_value < lo_r || byte_value > hi_r) begin
        err_vld = 1'b1;
      end else begin
        lo_nxt   = CONT_LO;
        hi_nxt   = CONT_HI;
        part_nxt = acc_cp;
        need_nxt = need_r - 2'd1;
        if (need_r == 2'd1) begin
          cp       = acc_cp;
          part_nxt = '0;
          complete = 1'b1;
        end
      end

      if (complete) begin
        if (!is_xml_char(cp)) begin
          err_vld  = 1'b1;
          err_kind = KIND_NOT_CHAR;
        end else begin
          if (cp == CP_CR) begin
            cp     = CP_LF;
            cr_nxt = 1'b1;
          end
          r0_vld  = 1'b1;
          r0.kind = KIND_CHAR;
          r0.cp   = cp;
          r0.line = FIELD_W'(line_r);
          r0.col  = FIELD_W'(col_r);
          if (cp == CP_LF) begin
            if (line_r != POS_MAX) line_nxt = line_r + POS_ONE;
            col_nxt = POS_ONE;
          end else if (col_r != POS_MAX) begin
            col_nxt = col_r + POS_ONE;
          end
        end
      end

      if (!err_vld && last_byte && need_nxt != 2'd0) err_vld = 1'b1;

      if (err_vld) begin
        r0_vld       = 1'b1;
        r0.kind      = err_kind;
        r0.cp        = '0;
        r0.line      = FIELD_W'(line_r);
        r0.col       = FIELD_W'(col_r);
        err_seen_nxt = 1'b1;
        part_nxt     = '0;
        need_nxt     = 2'd0;
        lo_nxt       = CONT_LO;
        hi_nxt       = CONT_HI;
        cr_nxt       = 1'b0;
      end
    end

    // end item at the position after the last character, then reset
    r_end.kind = KIND_END;
    r_end.cp   = '0;
    r_end.line = FIELD_W'(line_nxt);
    r_end.col  = FIELD_W'(col_nxt);
    r_end.fin  = 1'b1;
    r0.fin     = !last_byte;
    if (last_byte) begin
      part_nxt     = '0;
      need_nxt     = 2'd0;
      lo_nxt       = CONT_LO;
      hi_nxt       = CONT_HI;
      cr_nxt       = 1'b0;
      line_nxt     = POS_ONE;
      col_nxt      = POS_ONE;
      err_seen_nxt = 1'b0;
    end

    push = '0;
    if (acc) begin
      if (r0_vld) begin
        push.slot0 = r0;
        push.slot1 = r_end;
        push.n     = last_byte ? 2'd2 : 2'd1;
      end else begin
        push.slot0 = r_end;
        push.n     = last_byte ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r     <= '0;
      need_r     <= 2'd0;
      lo_r       <= CONT_LO;
      hi_r       <= CONT_HI;
      cr_r       <= 1'b0;
      line_r     <= POS_ONE;
      col_r      <= POS_ONE;
      err_seen_r <= 1'b0;
    end else if (acc) begin
      part_r     <= part_nxt;
      need_r     <= need_nxt;
      lo_r       <= lo_nxt;
      hi_r       <= hi_nxt;
      cr_r       <= cr_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

  `XUCR_ASSERT_IMPL(a_err_clears_dec, err_seen_r, need_r == 2'd0 && !cr_r, "decoder not cleared after error")
  `XUCR_ASSERT_IMPL(a_idle_bounds, need_r == 2'd0, lo_r == CONT_LO && hi_r == CONT_HI, "bounds left narrowed between sequences")
  `XUCR_ASSERT_NEXT(a_last_resets, acc && last_byte, line_r == POS_ONE && col_r == POS_ONE && !err_seen_r, "state not reset after end of entity")

endmodule

// ===== hw/rtl/xucr_fifo.sv =====
// Result queue of the XML UTF-8 character reader: takes up to two results a cycle.
// Depends on xucr_pkg; registered head drives the output channel.
`include "xml_utf8_char_reader_macros.svh"

module xucr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  xucr_pkg::push_t push,
  output logic            no_room,
  output logic            out_valid,
  input  logic            out_stall,
  output xucr_pkg::res_t  head
);
  import xucr_pkg::*;

  res_t               ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = ent_r[rp_r];
  // hold off input unless two free slots remain
  assign no_room   = (cnt_r > FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(push.n);
    rp_nxt  = rp_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push.n) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) ent_r[wp_r] <= push.slot0;
    if (push.n == 2'd2) ent_r[wp_r + FIFO_AW'(1)] <= push.slot1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `XUCR_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= FIFO_CW'(FIFO_DEPTH), "result queue count out of range")
  `XUCR_ASSERT_IMPL(a_no_overflow, push.n != 2'd0, cnt_r <= FIFO_CW'(FIFO_DEPTH - 2), "push into a queue without room")
  `XUCR_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(head), "stalled result changed or dropped")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the XML UTF-8 character reader (xml_utf8_char_reader).
// Holds its own byte-level decoder model and result checker; needs only xucr_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xucr_pkg::*;

  // Saturation point of the 32-bit line and column counters.
  localparam logic [31:0] POSITION_TOP = 32'hFFFF_FFFF;
  // Worst case stays far below this; it only catches a hung handshake.
  localparam int          CYCLE_LIMIT  = 200_000;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] cp;
    logic [31:0] line;
    logic [31:0] col;
    logic        fin;
  } char_event_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_last_byte  = 1'b0;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [20:0] out_code_point;
  logic [31:0] out_line_number;
  logic [31:0] out_column_number;
  logic        out_final_of_run;

  // Decoder model state: one copy, advanced on every accepted byte.
  logic [20:0] acc_cp;
  logic [1:0]  need_cnt;
  logic [7:0]  cont_lo;
  logic [7:0]  cont_hi;
  logic        pending_cr;
  logic [31:0] cur_line;
  logic [31:0] cur_col;
  logic        in_error;

  // Results the model has produced and the block has not yet delivered.
  char_event_t char_events[$];
  logic [7:0]  entity_bytes[$];

  int errors      = 0;
  int cycle_count = 0;
  int bytes_sent  = 0;

  // Idling knobs, set per test. stall_max of zero means the receiver never stalls;
  // gap_max of zero means requests go back to back.
  int gap_max    = 0;
  int burst_max  = 1;
  int burst_left = 0;
  int stall_max  = 0;
  int free_max   = 1;
  int stall_run  = 0;
  logic stall_on = 1'b0;

  xml_utf8_char_reader i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_code_point    (out_code_point),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_final_of_run  (out_final_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run; a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results still pending", $time,
               char_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall pattern: alternate stalled and free runs of random length.
  // Drive at the falling edge so the block sees a settled value at the rising edge.
  always @(negedge clk) begin
    if (stall_max == 0) begin
      out_stall <= 1'b0;
      stall_on = 1'b0;
      stall_run = 0;
    end else if (stall_run == 0) begin
      stall_on = !stall_on;
      stall_run = stall_on ? $urandom_range(stall_max, 1) : $urandom_range(free_max, 1);
      out_stall <= stall_on;
    end else begin
      stall_run--;
    end
  end

  // Check every delivered result against the oldest pending model result.
  always @(posedge clk) begin : check_results
    char_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (char_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d cp %h line %0d col %0d",
                 $time, out_kind, out_code_point, out_line_number, out_column_number);
        errors++;
      end else begin
        want = char_events.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, out_kind);
          errors++;
        end
        if (out_code_point !== want.cp) begin
          $display("%0t: code_point mismatch: expected %h, actual %h", $time, want.cp,
                   out_code_point);
          errors++;
        end
        if (out_line_number !== want.line) begin
          $display("%0t: line_number mismatch: expected %0d, actual %0d", $time, want.line,
                   out_line_number);
          errors++;
        end
        if (out_column_number !== want.col) begin
          $display("%0t: column_number mismatch: expected %0d, actual %0d", $time, want.col,
                   out_column_number);
          errors++;
        end
        if (out_final_of_run !== want.fin) begin
          $display("%0t: final_of_run mismatch: expected %0b, actual %0b", $time, want.fin,
                   out_final_of_run);
          errors++;
        end
      end
    end
  end

  // Return the model to its post-reset state (also done after every entity end).
  function automatic void reset_decoder();
    acc_cp     = '0;
    need_cnt   = 2'd0;
    cont_lo    = 8'h80;
    cont_hi    = 8'hBF;
    pending_cr = 1'b0;
    cur_line   = 32'd1;
    cur_col    = 32'd1;
    in_error   = 1'b0;
  endfunction

  // Advance the model by one accepted byte and queue the results it causes.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    char_event_t made[2];
    int          n_made;
    logic        was_cr;
    logic        done;
    logic        faulted;
    kind_t       fault;
    logic [20:0] cp;
    n_made  = 0;
    done    = 1'b0;
    faulted = 1'b0;
    fault   = KIND_BAD_UTF8;
    cp      = '0;
    if (!in_error) begin
      was_cr = pending_cr;
      pending_cr = 1'b0;
      if (need_cnt == 2'd0) begin
        if (b < 8'h80) begin
          // LF right after CR was already reported as the CR's LF: drop it.
          if (!(was_cr && b == 8'h0A)) begin
            cp = {13'd0, b};
            done = 1'b1;
          end
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          need_cnt = 2'd1;
          acc_cp = {16'd0, b[4:0]};
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          if (b == 8'hE0) cont_lo = 8'hA0;
          if (b == 8'hED) cont_hi = 8'h9F;
          need_cnt = 2'd2;
          acc_cp = {17'd0, b[3:0]};
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          if (b == 8'hF0) cont_lo = 8'h90;
          if (b == 8'hF4) cont_hi = 8'h8F;
          need_cnt = 2'd3;
          acc_cp = {18'd0, b[2:0]};
        end else begin
          faulted = 1'b1;
        end
      end else if (b < cont_lo || b > cont_hi) begin
        faulted = 1'b1;
      end else begin
        cont_lo = 8'h80;
        cont_hi = 8'hBF;
        acc_cp = {acc_cp[14:0], b[5:0]};
        need_cnt = need_cnt - 2'd1;
        if (need_cnt == 2'd0) begin
          cp = acc_cp;
          acc_cp = '0;
          done = 1'b1;
        end
      end

      if (done) begin
        if (!(cp == 21'h09 || cp == 21'h0A || cp == 21'h0D ||
              (cp >= 21'h20 && cp <= 21'hD7FF) ||
              (cp >= 21'hE000 && cp <= 21'hFFFD) ||
              (cp >= 21'h10000 && cp <= 21'h10FFFF))) begin
          faulted = 1'b1;
          fault = KIND_NOT_CHAR;
        end else begin
          if (cp == 21'h0D) begin
            cp = 21'h0A;
            pending_cr = 1'b1;
          end
          made[n_made] = '{KIND_CHAR, cp, cur_line, cur_col, 1'b0};
          n_made++;
          if (cp == 21'h0A) begin
            if (cur_line != POSITION_TOP) cur_line++;
            cur_col = 32'd1;
          end else if (cur_col != POSITION_TOP) begin
            cur_col++;
          end
        end
      end
      // Entity ends inside a sequence: ill-formed.
      if (!faulted && last && need_cnt != 2'd0) faulted = 1'b1;
      if (faulted) begin
        // Report at the position where the sequence began; do not advance.
        made[n_made] = '{fault, 21'd0, cur_line, cur_col, 1'b0};
        n_made++;
        in_error = 1'b1;
        acc_cp   = '0;
        need_cnt = 2'd0;
        cont_lo  = 8'h80;
        cont_hi  = 8'hBF;
        pending_cr = 1'b0;
      end
    end
    if (last) begin
      made[n_made] = '{KIND_END, 21'd0, cur_line, cur_col, 1'b0};
      n_made++;
      reset_decoder();
    end
    for (int i = 0; i < n_made; i++) begin
      made[i].fin = (i == n_made - 1);
      char_events.push_back(made[i]);
    end
  endfunction

  // Send one byte request. Called and returning at a falling edge; valid stays high
  // on return so the next request can follow without a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(negedge clk);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    // Hold the request until the block takes it.
    do @(posedge clk); while (in_stall);
    decode_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Append the UTF-8 form of a code point to the entity under construction.
  function automatic void push_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      entity_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      entity_bytes.push_back({3'b110, cp[10:6]});
      entity_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      entity_bytes.push_back({4'b1110, cp[15:12]});
      entity_bytes.push_back({2'b10, cp[11:6]});
      entity_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      entity_bytes.push_back({5'b11110, cp[20:18]});
      entity_bytes.push_back({2'b10, cp[17:12]});
      entity_bytes.push_back({2'b10, cp[11:6]});
      entity_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Build one entity of random characters, bad_pct percent of them broken, and send it
  // with the last flag on its final byte.
  task automatic send_entity(input int max_chars, input int bad_pct);
    int          n_chars;
    int          n_bytes;
    logic [7:0]  lead;
    logic [20:0] cp;
    entity_bytes.delete();
    n_chars = $urandom_range(max_chars, 1);
    repeat (n_chars) begin
      if ($urandom_range(99) >= bad_pct) begin
        // Well-formed XML character; weight toward ASCII and line ends.
        case ($urandom_range(9))
          0, 1, 2, 3: cp = 21'($urandom_range(21'h7E, 21'h20));
          4: cp = $urandom_range(1) ? 21'h0A : 21'h09;
          5: begin
            push_utf8(21'h0D);
            cp = $urandom_range(1) ? 21'h0A : 21'($urandom_range(21'h7E, 21'h20));
          end
          6: cp = 21'($urandom_range(21'h7FF, 21'h80));
          7: cp = $urandom_range(1) ? 21'($urandom_range(21'hD7FF, 21'h800))
                                    : 21'($urandom_range(21'hFFFD, 21'hE000));
          default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
        push_utf8(cp);
      end else begin
        case ($urandom_range(4))
          // Noise: any byte at all.
          0: entity_bytes.push_back(8'($urandom_range(255)));
          // Well-formed UTF-8 that is not an XML Char.
          1: begin
            if ($urandom_range(1)) begin
              cp = 21'($urandom_range(31));
              if (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D) cp = 21'h0B;
            end else begin
              cp = 21'hFFFE | 21'($urandom_range(1));
            end
            push_utf8(cp);
          end
          // Lead byte, maybe one continuation, then cut short by whatever follows.
          2: begin
            lead = 8'($urandom_range(8'hF4, 8'hC2));
            entity_bytes.push_back(lead);
            if (((lead >= 8'hE1 && lead <= 8'hEF && lead != 8'hED) ||
                 (lead >= 8'hF1 && lead <= 8'hF3)) && $urandom_range(1))
              entity_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
          end
          // Continuation outside the narrowed range of E0, ED, F0 or F4.
          3: begin
            case ($urandom_range(3))
              0: begin
                entity_bytes.push_back(8'hE0);
                entity_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
              end
              1: begin
                entity_bytes.push_back(8'hED);
                entity_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
              end
              2: begin
                entity_bytes.push_back(8'hF0);
                entity_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
              end
              default: begin
                entity_bytes.push_back(8'hF4);
                entity_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
              end
            endcase
          end
          // Stray continuation or a lead byte that never starts a sequence.
          default: begin
            case ($urandom_range(2))
              0: entity_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
              1: entity_bytes.push_back(8'($urandom_range(8'hC1, 8'hC0)));
              default: entity_bytes.push_back(8'($urandom_range(8'hFF, 8'hF5)));
            endcase
          end
        endcase
      end
    end
    n_bytes = entity_bytes.size();
    for (int i = 0; i < n_bytes; i++) send_byte(entity_bytes[i], i == n_bytes - 1);
  endtask

  // Hand-picked entities: line ends, extremes, each error kind and where it lands.
  task automatic test_directed_cases();
    // Bit 8 carries the last-byte flag.
    logic [8:0] script[26];
    script = '{
      9'h041, 9'h00D, 9'h00A, 9'h009,        // A, CR-LF collapses to one LF, TAB
      9'h00D, 9'h00D, 9'h17E,                // CR CR gives two LFs, then ~ and end
      9'h0C2, 9'h080,                        // smallest two-byte form
      9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,        // U+10FFFF, then end
      9'h0E0, 9'h09F, 9'h041, 9'h1FF,        // overlong; rest dropped until end
      9'h0ED, 9'h1A0,                        // surrogate lead pair at end
      9'h100,                                // NUL alone: not an XML Char
      9'h041, 9'h0EF, 9'h0BF, 9'h1BE,        // U+FFFE: not an XML Char, after a char
      9'h0F0, 9'h190                         // four-byte form cut short at end
    };
    gap_max   = 3;
    burst_max = 4;
    stall_max = 3;
    free_max  = 4;
    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);
  endtask

  // Mostly well-formed text with random content, light idling on both sides.
  task automatic test_wellformed_text();
    gap_max   = 4;
    burst_max = 12;
    stall_max = 2;
    free_max  = 10;
    while (bytes_sent < 230) send_entity(24, 3);
  endtask

  // Heavy share of noise and broken sequences in short entities.
  task automatic test_malformed_input();
    gap_max   = 2;
    burst_max = 6;
    stall_max = 4;
    free_max  = 4;
    while (bytes_sent < 360) send_entity(8, 40);
  endtask

  // No idling on either side: full rate, two-result bytes back to back.
  task automatic test_back_to_back();
    gap_max   = 0;
    stall_max = 0;
    while (bytes_sent < 450) send_entity(6, 15);
  endtask

  // Long receiver stalls fill the result queue and push back on the sender.
  task automatic test_heavy_stall();
    gap_max   = 1;
    burst_max = 20;
    stall_max = 12;
    free_max  = 2;
    while (bytes_sent < 520) send_entity(4, 20);
  endtask

  initial begin
    reset_decoder();
    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_wellformed_text();
    test_malformed_input();
    test_back_to_back();
    test_heavy_stall();

    // Drop valid, drain every pending result, then allow for the output latency.
    in_valid <= 1'b0;
    stall_max = 2;
    free_max  = 3;
    while (char_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
